// ----- sv/frc16_pkg.sv -----
`default_nettype none

package frc16_pkg;

  // Default geometry of the receive buffer and header
  localparam int RxBufferBytesDefault = 256;
  localparam int HeaderBytesDefault   = 8;
  localparam int LengthOffsetDefault  = 6;

  // Header length plus payload length plus CRC needs one bit above the length field
  localparam int TotalW = 17;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0]  StartMarkerReset  = 8'd170;
  localparam logic [7:0]  PayloadLimitReset = 8'd246;
  localparam logic [15:0] SilenceLimitReset = 16'd2000;

  typedef enum logic [1:0] {
    REG_START_MARKER  = 2'd0,
    REG_PAYLOAD_LIMIT = 2'd1,
    REG_SILENCE_LIMIT = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_GOOD      = 3'd0,
    EV_OVERSIZE  = 3'd1,
    EV_OVERLIMIT = 3'd2,
    EV_CRC       = 3'd3,
    EV_TIMEOUT   = 3'd4
  } event_t;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  payload_limit;
    logic [15:0] silence_limit;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    event_t      code;
    logic [7:0]  ftype;
    logic [7:0]  fseq;
    logic [15:0] flen;
    logic        link;
  } result_t;

  // CRC-16/CCITT, MSB first, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/frc16_parser.sv -----
`default_nettype none

module frc16_parser import frc16_pkg::*; #(
  parameter int RX_BUFFER_BYTES = RxBufferBytesDefault,
  parameter int HEADER_BYTES    = HeaderBytesDefault,
  parameter int LENGTH_OFFSET   = LengthOffsetDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       func,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output result_t         res
);

  localparam int CountW = $clog2(RX_BUFFER_BYTES + 1);

  phase_t              phase, phase_next;
  logic [CountW-1:0]   byte_count, byte_count_next;
  logic [CountW-1:0]   frame_total, frame_total_next;
  logic [15:0]         crc_reg, crc_reg_next;
  logic [7:0]          hdr_type, hdr_type_next;
  logic [7:0]          hdr_seq, hdr_seq_next;
  logic [15:0]         hdr_len, hdr_len_next;
  logic                connected, connected_next;
  logic [15:0]         idle_ticks, idle_ticks_next;

  logic [CountW-1:0]   count_inc;
  logic [15:0]         crc_upd;
  logic [TotalW-1:0]   total;
  logic                hdr_done, too_big, body_done, is_start;

  // Header field capture for the current byte
  always_comb begin
    hdr_type_next = hdr_type;
    hdr_seq_next  = hdr_seq;
    hdr_len_next  = hdr_len;
    if (phase == PH_HEADER) begin
      if (byte_count == '0) hdr_type_next = rx_byte;
      if (byte_count == CountW'(1)) hdr_seq_next = rx_byte;
      if (byte_count == CountW'(LENGTH_OFFSET)) hdr_len_next[7:0] = rx_byte;
      if (byte_count == CountW'(LENGTH_OFFSET + 1)) hdr_len_next[15:8] = rx_byte;
    end else if (phase != PH_BODY && rx_byte == cfg.start_marker) begin
      hdr_type_next = '0;
      hdr_seq_next  = '0;
      hdr_len_next  = '0;
    end
  end

  assign count_inc = byte_count + CountW'(1);
  assign crc_upd   = crc16_byte(crc_reg, rx_byte);
  assign total     = TotalW'(HEADER_BYTES) + {1'b0, hdr_len_next} + TotalW'(2);
  assign hdr_done  = count_inc >= CountW'(HEADER_BYTES);
  assign too_big   = total > TotalW'(RX_BUFFER_BYTES);
  assign body_done = count_inc >= frame_total;
  assign is_start  = rx_byte == cfg.start_marker;
  assign idle_ticks_next = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;

  // Next phase
  always_comb begin
    phase_next = phase;
    if (!func) begin
      case (phase)
        PH_HEADER: begin
          if (hdr_done) phase_next = too_big ? PH_HUNT : PH_BODY;
        end
        PH_BODY: begin
          if (body_done) phase_next = PH_HUNT;
        end
        default: begin
          phase_next = is_start ? PH_HEADER : PH_HUNT;
        end
      endcase
    end
  end

  // Datapath updates and result
  always_comb begin
    byte_count_next  = byte_count;
    frame_total_next = frame_total;
    crc_reg_next     = crc_reg;
    connected_next   = connected;
    res.valid = 1'b0;
    res.code  = EV_GOOD;
    res.ftype = hdr_type_next;
    res.fseq  = hdr_seq_next;
    res.flen  = hdr_len_next;
    if (func) begin
      if (connected && idle_ticks_next > cfg.silence_limit) begin
        connected_next = 1'b0;
        res.valid = 1'b1;
        res.code  = EV_TIMEOUT;
        res.ftype = '0;
        res.fseq  = '0;
        res.flen  = '0;
      end
    end else begin
      case (phase)
        PH_HEADER: begin
          crc_reg_next    = crc_upd;
          byte_count_next = count_inc;
          if (hdr_done) begin
            frame_total_next = total[CountW-1:0];
            if (too_big) begin
              res.valid = 1'b1;
              res.code  = EV_OVERSIZE;
            end
          end
        end
        PH_BODY: begin
          crc_reg_next    = crc_upd;
          byte_count_next = count_inc;
          if (body_done) begin
            res.valid = 1'b1;
            if (hdr_len > {8'h00, cfg.payload_limit}) begin
              res.code = EV_OVERLIMIT;
            end else if (crc_upd != 16'h0000) begin
              res.code = EV_CRC;
            end else begin
              res.code       = EV_GOOD;
              connected_next = 1'b1;
            end
          end
        end
        default: begin
          if (is_start) begin
            byte_count_next  = '0;
            frame_total_next = '0;
            crc_reg_next     = CrcInit;
          end
        end
      endcase
    end
    res.link  = connected_next;
    res.valid = res.valid & step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      connected  <= 1'b0;
      idle_ticks <= '0;
      byte_count <= '0;
      frame_total <= '0;
      crc_reg    <= CrcInit;
      hdr_type   <= '0;
      hdr_seq    <= '0;
      hdr_len    <= '0;
    end else if (step) begin
      phase     <= phase_next;
      connected <= connected_next;
      if (func) begin
        idle_ticks <= idle_ticks_next;
      end else if (res.valid && res.code == EV_GOOD) begin
        idle_ticks <= '0;
      end
      if (!func) begin
        byte_count  <= byte_count_next;
        frame_total <= frame_total_next;
        crc_reg     <= crc_reg_next;
        hdr_type    <= hdr_type_next;
        hdr_seq     <= hdr_seq_next;
        hdr_len     <= hdr_len_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/frame_receiver_crc16.sv -----
// Frame receiver with CRC-16/CCITT check and link supervision.
// Input channel (in_valid / in_stall): each transfer is one item, either a
// received byte (func = 0, rx_byte) or one time tick (func = 1).
// Output channel (out_valid / out_stall): one transfer per reported event:
// good frame, oversize abort, length over limit, CRC mismatch or link
// timeout, with the header fields and the link state after the event.
// Most items report nothing; at most one event per item.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// start marker, 1 payload limit, 2 silence limit; other indexes ignored.
// cfg_ready is always high; write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. An item sits in the
// input register, is parsed and its event lands in the output register, from
// which the event transfers once out_stall is low.
// A stalled output register holds its event and stalls the input register,
// which then raises in_stall; no item or event is dropped.
// Reset (rst, synchronous) returns the parser to hunting, drops the link,
// clears the idle count and restores the register defaults.
`default_nettype none

module frame_receiver_crc16 import frc16_pkg::*; #(
  parameter int RX_BUFFER_BYTES = RxBufferBytesDefault,
  parameter int HEADER_BYTES    = HeaderBytesDefault,
  parameter int LENGTH_OFFSET   = LengthOffsetDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       event_code,
  output logic [7:0]       frame_type,
  output logic [7:0]       frame_seq,
  output logic [15:0]      frame_len,
  output logic             link_up,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t       cfg;
  logic       s1_valid;
  logic       s1_func;
  logic [7:0] s1_byte;
  logic       advance;
  result_t    res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker  <= StartMarkerReset;
      cfg.payload_limit <= PayloadLimitReset;
      cfg.silence_limit <= SilenceLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_START_MARKER:  cfg.start_marker  <= cfg_data[7:0];
        REG_PAYLOAD_LIMIT: cfg.payload_limit <= cfg_data[7:0];
        REG_SILENCE_LIMIT: cfg.silence_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the output register can take a result
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func <= func;
      s1_byte <= rx_byte;
    end
  end

  frc16_parser #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES),
    .HEADER_BYTES   (HEADER_BYTES),
    .LENGTH_OFFSET  (LENGTH_OFFSET)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_valid && advance),
    .func   (s1_func),
    .rx_byte(s1_byte),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      event_code <= res.code;
      frame_type <= res.ftype;
      frame_seq  <= res.fseq;
      frame_len  <= res.flen;
      link_up    <= res.link;
    end
  end

endmodule

`default_nettype wire

// ----- dv/frc16_tb_pkg.sv -----
`timescale 1ns / 1ps

package frc16_tb_pkg;
  import frc16_pkg::*;

  // Bit-serial CRC-16/CCITT step: feedback is the top CRC bit xor the next data bit
  function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] crc,
                                                   input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

endpackage

// ----- dv/frame_receiver_crc16_check.sv -----
`timescale 1ns / 1ps

module frame_receiver_crc16_check
  import frc16_pkg::*;
  import frc16_tb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        func,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  event_code,
  input  wire logic [7:0]  frame_type,
  input  wire logic [7:0]  frame_seq,
  input  wire logic [15:0] frame_len,
  input  wire logic        link_up,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam int MaxReports = 10;

  typedef struct packed {
    event_t      code;
    logic [7:0]  ftype;
    logic [7:0]  fseq;
    logic [15:0] flen;
    logic        link;
  } frame_report_t;

  frame_report_t expected_events[$];

  logic [7:0]  marker_byte;
  logic [7:0]  max_payload;
  logic [15:0] silence_max;

  phase_t      stage;
  logic [8:0]  bytes_seen;
  logic [16:0] frame_bytes;
  logic [15:0] running_crc;
  logic [7:0]  cap_type;
  logic [7:0]  cap_seq;
  logic [15:0] cap_len;
  logic        link;
  logic [15:0] silent_ticks;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_event(input event_t code, input logic with_header);
    frame_report_t r;
    r.code  = code;
    r.ftype = with_header ? cap_type : 8'h00;
    r.fseq  = with_header ? cap_seq : 8'h00;
    r.flen  = with_header ? cap_len : 16'h0000;
    r.link  = link;
    expected_events.push_back(r);
  endtask

  task automatic step_deframer(input logic is_tick, input logic [7:0] b);
    if (is_tick) begin
      if (silent_ticks != 16'hFFFF) silent_ticks++;
      if (link && silent_ticks > silence_max) begin
        link = 1'b0;
        report_event(EV_TIMEOUT, 1'b0);
      end
    end else begin
      case (stage)
        PH_HEADER: begin
          if (bytes_seen == 9'd0) cap_type = b;
          if (bytes_seen == 9'd1) cap_seq = b;
          if (bytes_seen == 9'(LengthOffsetDefault)) cap_len[7:0] = b;
          if (bytes_seen == 9'(LengthOffsetDefault + 1)) cap_len[15:8] = b;
          running_crc = crc16_ccitt_next(running_crc, b);
          bytes_seen++;
          if (bytes_seen >= 9'(HeaderBytesDefault)) begin
            frame_bytes = 17'(HeaderBytesDefault) + 17'(cap_len) + 17'd2;
            if (frame_bytes > 17'(RxBufferBytesDefault)) begin
              stage = PH_HUNT;
              report_event(EV_OVERSIZE, 1'b1);
            end else begin
              stage = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          running_crc = crc16_ccitt_next(running_crc, b);
          bytes_seen++;
          if (17'(bytes_seen) >= frame_bytes) begin
            stage = PH_HUNT;
            if (cap_len > 16'(max_payload)) begin
              report_event(EV_OVERLIMIT, 1'b1);
            end else if (running_crc != 16'h0000) begin
              report_event(EV_CRC, 1'b1);
            end else begin
              link = 1'b1;
              silent_ticks = 16'h0000;
              report_event(EV_GOOD, 1'b1);
            end
          end
        end
        default: begin
          // hunting; the unused phase code lands here too
          stage = PH_HUNT;
          if (b == marker_byte) begin
            stage = PH_HEADER;
            bytes_seen = 9'd0;
            frame_bytes = 17'd0;
            running_crc = CrcInit;
            cap_type = 8'h00;
            cap_seq = 8'h00;
            cap_len = 16'h0000;
          end
        end
      endcase
    end
  endtask

  task automatic check_event();
    frame_report_t want;
    if (expected_events.size() == 0) begin
      if (fail_count < MaxReports)
        $display("%0t: unexpected event code %0d type %02h seq %02h len %04h link %0d",
                 $time, event_code, frame_type, frame_seq, frame_len, link_up);
      fail_count++;
    end else begin
      want = expected_events.pop_front();
      if (event_code !== want.code || frame_type !== want.ftype ||
          frame_seq !== want.fseq || frame_len !== want.flen || link_up !== want.link) begin
        if (fail_count < MaxReports)
          $display("%0t: expected code %0d type %02h seq %02h len %04h link %0d; ",
                   $time, want.code, want.ftype, want.fseq, want.flen, want.link,
                   "got code %0d type %02h seq %02h len %04h link %0d",
                   event_code, frame_type, frame_seq, frame_len, link_up);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      marker_byte = StartMarkerReset;
      max_payload = PayloadLimitReset;
      silence_max = SilenceLimitReset;
      stage = PH_HUNT;
      bytes_seen = 9'd0;
      frame_bytes = 17'd0;
      running_crc = CrcInit;
      cap_type = 8'h00;
      cap_seq = 8'h00;
      cap_len = 16'h0000;
      link = 1'b0;
      silent_ticks = 16'h0000;
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_MARKER:  marker_byte = cfg_data[7:0];
          REG_PAYLOAD_LIMIT: max_payload = cfg_data[7:0];
          REG_SILENCE_LIMIT: silence_max = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) step_deframer(func, rx_byte);
      if (out_valid && !out_stall) check_event();
    end
    pending = expected_events.size();
  end

endmodule

// ----- dv/frame_receiver_crc16_test.sv -----
`timescale 1ns / 1ps

module frame_receiver_crc16_test;
  import frc16_pkg::*;
  import frc16_tb_pkg::*;

  localparam int StuckLimit = 5000;
  localparam int HoldCycles = 300;
  localparam int IdlePct    = 19;
  localparam int MaxFit     = RxBufferBytesDefault - HeaderBytesDefault - 2;
  localparam logic [1:0] RegUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_code;
  logic [7:0]  frame_type;
  logic [7:0]  frame_seq;
  logic [15:0] frame_len;
  logic        link_up;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;
  int          fail_count;
  int          pending;

  logic        quiet = 1'b0;
  logic        hold_ask = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  int          items_sent = 0;
  logic [7:0]  cur_marker = StartMarkerReset;
  logic [7:0]  cur_limit = PayloadLimitReset;
  logic [15:0] cur_silence = SilenceLimitReset;

  frame_receiver_crc16 uut (.*);
  frame_receiver_crc16_check chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: random stall, or a long hold-off counted here when asked
  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  task automatic send_item(input logic f, input logic [7:0] b);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // cut > 0 truncates the frame after that many bytes past the start byte
  task automatic drive_frame(input logic [7:0] ftype, input logic [7:0] fseq,
                             input logic [15:0] flen, input logic bad_crc, input int cut);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          pos;
    for (int i = 0; i < HeaderBytesDefault; i++) begin
      if (i == 0) body.push_back(ftype);
      else if (i == 1) body.push_back(fseq);
      else if (i == LengthOffsetDefault) body.push_back(flen[7:0]);
      else if (i == LengthOffsetDefault + 1) body.push_back(flen[15:8]);
      else body.push_back(8'($urandom));
    end
    // oversize frames abort after the header, so only the header goes out
    if (int'(flen) <= MaxFit) begin
      repeat (flen) body.push_back(8'($urandom));
      crc = CrcInit;
      foreach (body[i]) crc = crc16_ccitt_next(crc, body[i]);
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
      if (bad_crc) begin
        pos = $urandom_range(HeaderBytesDefault, body.size() - 1);
        body[pos] = body[pos] ^ 8'($urandom_range(1, 255));
      end
    end
    if (cut > 0 && cut < body.size()) body = body[0:cut-1];
    send_item(1'b0, cur_marker);
    foreach (body[i]) begin
      if ($urandom_range(99) < 6) send_item(1'b1, 8'($urandom));
      send_item(1'b0, body[i]);
    end
  endtask

  function automatic int pick_len();
    int r;
    int top;
    r = $urandom_range(99);
    top = int'(cur_limit) + 4;
    if (top > MaxFit) top = MaxFit;
    if (r < 70) return $urandom_range(0, 10);
    if (r < 98) return $urandom_range(0, top);
    return $urandom_range(1) ? MaxFit : $urandom_range(200, MaxFit);
  endfunction

  task automatic random_traffic(input int n);
    int          stop_at;
    int          r;
    int          burst;
    logic [15:0] flen;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 55) begin
        drive_frame(8'($urandom), 8'($urandom), 16'(pick_len()),
                    $urandom_range(99) < 20, 0);
      end else if (r < 65) begin
        drive_frame(8'($urandom), 8'($urandom),
                    16'($urandom_range(MaxFit + 1, 65535)), 1'b0, 0);
      end else if (r < 77) begin
        burst = (cur_silence < 16'd30) ? $urandom_range(1, int'(cur_silence) + 3)
                                       : $urandom_range(1, 8);
        repeat (burst) send_item(1'b1, 8'($urandom));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 6)) send_item(1'b0, 8'($urandom));
      end else begin
        flen = 16'(pick_len());
        drive_frame(8'($urandom), 8'($urandom), flen, 1'b0,
                    $urandom_range(1, HeaderBytesDefault + int'(flen) + 1));
      end
    end
  endtask

  // drop valid, wait for every outstanding event, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] marker, input logic [7:0] limit,
                                input logic [15:0] silence);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    idx = '{REG_START_MARKER, REG_PAYLOAD_LIMIT, REG_SILENCE_LIMIT, RegUnused};
    val = '{{8'($urandom), marker}, {8'($urandom), limit}, silence, 16'($urandom)};
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_marker = marker;
    cur_limit = limit;
    cur_silence = silence;
  endtask

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // reset settings: good, bad CRC, start byte as data, oversize at both ends
    drive_frame(8'h00, 8'hFF, 16'd0, 1'b0, 0);
    drive_frame(8'hFF, 8'h00, 16'd1, 1'b1, 0);
    drive_frame(StartMarkerReset, StartMarkerReset, 16'd2, 1'b0, 0);
    drive_frame(8'h5A, 8'hA5, 16'(MaxFit + 1), 1'b0, 0);
    drive_frame(8'h01, 8'h80, 16'hFFFF, 1'b0, 0);
    repeat (3) send_item(1'b1, 8'($urandom));
    settle();

    // zero silence drops the link on the first tick; zero limit rejects any payload
    apply_settings(8'h00, 8'h00, 16'h0000);
    send_item(1'b1, 8'hFF);
    drive_frame(8'h11, 8'h22, 16'd1, 1'b0, 0);
    drive_frame(8'h33, 8'h44, 16'd0, 1'b1, 0);
    drive_frame(8'h55, 8'h66, 16'd0, 1'b0, 0);
    send_item(1'b1, 8'h00);
    settle();

    apply_settings(8'($urandom), 8'($urandom_range(0, MaxFit)),
                   16'($urandom_range(1, 30)));
    random_traffic(200);
    settle();
    apply_settings(8'h00, 8'h00, 16'd1);
    random_traffic(100);
    settle();
    apply_settings(8'hFF, 8'hFF, 16'h0000);
    random_traffic(100);
    settle();

    // stretch with no idling on either side
    apply_settings(StartMarkerReset, 8'(MaxFit), 16'd12);
    quiet <= 1'b1;
    random_traffic(160);
    quiet <= 1'b0;
    settle();

    // long receiver hold-off while short frames keep coming, then drain fully
    apply_settings(8'($urandom), 8'($urandom_range(0, MaxFit)),
                   16'($urandom_range(2, 20)));
    hold_ask <= ~hold_ask;
    repeat (6) drive_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, 3)), 1'b0, 0);
    settle();
    random_traffic(130);
    settle();

    // no timeout at the top silence limit, then a lower limit trips on the next tick
    apply_settings(8'h55, 8'(MaxFit), 16'hFFFF);
    drive_frame(8'h77, 8'h01, 16'd2, 1'b0, 0);
    repeat (40) send_item(1'b1, 8'($urandom));
    settle();
    apply_settings(8'h55, 8'(MaxFit), 16'd30);
    send_item(1'b1, 8'h00);
    drive_frame(8'h78, 8'h02, 16'd0, 1'b0, 0);
    settle();
    repeat (16) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
